>>> rtl/brainfuck_debug_core_assert.svh
// assertion macros for the brainfuck debug core
// used by the top level; each use names a clock, and BFDC_ASSERT also a reset
`ifndef BRAINFUCK_DEBUG_CORE_ASSERT_SVH
`define BRAINFUCK_DEBUG_CORE_ASSERT_SVH

// check that is ignored while reset is high
`define BFDC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bfdc check failed");

// check that also holds across reset
`define BFDC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bfdc check failed");

`endif

>>> rtl/bfdc_pkg.sv
// shared types, widths and opcodes of the brainfuck debug core
// no dependencies
package bfdc_pkg;

   // default sizes
   localparam int PROG_DEPTH_DEF = 4096;
   localparam int TAPE_DEPTH_DEF = 32768;
   localparam int FIFO_DEPTH_DEF = 16;

   // fixed field widths
   localparam int TYPE_W = 2;
   localparam int ADDR_W = 12;
   localparam int BYTE_W = 8;
   localparam int IP_W   = 13;
   localparam int LEN_W  = 13;
   localparam int ST_W   = 3;
   // wide enough to compare any index against any program depth
   localparam int EXT_W  = 18;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // program characters
   localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
   localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
   localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
   localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
   localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
   localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
   localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] NEWLINE  = 8'h0A;

   typedef enum logic [TYPE_W-1:0] {
      REQ_LOAD = 2'd0,
      REQ_PUSH = 2'd1,
      REQ_STEP = 2'd2,
      REQ_NOP  = 2'd3
   } req_kind_type;

   typedef enum logic [ST_W-1:0] {
      ST_EXEC     = 3'd0,
      ST_TARGET   = 3'd1,
      ST_END      = 3'd2,
      ST_NO_CLOSE = 3'd3,
      ST_NO_OPEN  = 3'd4,
      ST_WRAP     = 3'd5,
      ST_ACCEPT   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC,
      BK_SCAN_F,
      BK_SCAN_B
   } back_state_type;

   // one classified word waiting for the back end
   typedef struct packed {
      req_kind_type      kind;
      logic [ADDR_W-1:0] prog_addr;
      logic [BYTE_W-1:0] data_byte;
      logic [IP_W-1:0]   target_index;
   } item_type;

endpackage

>>> rtl/bfdc_req_if.sv
// request channel of the brainfuck debug core
// depends on bfdc_pkg
interface bfdc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfdc_pkg::TYPE_W-1:0]   req_type;
   logic [bfdc_pkg::ADDR_W-1:0]   prog_addr;
   logic [bfdc_pkg::BYTE_W-1:0]   data_byte;
   logic [bfdc_pkg::IP_W-1:0]     target_index;

   modport source (output valid, req_type, prog_addr, data_byte, target_index, input ready);
   modport sink (input valid, req_type, prog_addr, data_byte, target_index, output ready);
endinterface

>>> rtl/bfdc_rsp_if.sv
// response channel of the brainfuck debug core
// depends on bfdc_pkg
interface bfdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          out_valid;
   logic [bfdc_pkg::BYTE_W-1:0]   out_byte;
   logic [bfdc_pkg::ST_W-1:0]     status;
   logic [bfdc_pkg::IP_W-1:0]     instr_index;

   modport source (output valid, out_valid, out_byte, status, instr_index, input ready);
   modport sink (input valid, out_valid, out_byte, status, instr_index, output ready);
endinterface

>>> rtl/bfdc_front.sv
// front end: accepts request words, classifies them and queues them
// depends on bfdc_pkg and bfdc_req_if
module bfdc_front (
   input  logic               clock,
   input  logic               reset,
   bfdc_req_if.sink           req,
   output bfdc_pkg::item_type q_item,
   output logic               q_valid,
   input  logic               q_pop
);
   import bfdc_pkg::*;

   localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

   item_type          slot_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QC_W-1:0]   cnt_ff, cnt_in;
   logic              push;
   item_type          item_new;

   // classify the incoming word
   always_comb begin
      item_new.kind         = req_kind_type'(req.req_type);
      item_new.prog_addr    = req.prog_addr;
      item_new.data_byte    = req.data_byte;
      item_new.target_index = req.target_index;
   end

   assign req.ready = (cnt_ff < QC_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = slot_ff[rd_ff];

   // queue pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_in = (rd_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= item_new;
      end
   end

endmodule

>>> rtl/bfdc_back.sv
// back end: program, tape and input memories, step sequencer, response register
// depends on bfdc_pkg and bfdc_rsp_if
module bfdc_back #(
   parameter int PROG_DEPTH = bfdc_pkg::PROG_DEPTH_DEF,
   parameter int TAPE_DEPTH = bfdc_pkg::TAPE_DEPTH_DEF,
   parameter int FIFO_DEPTH = bfdc_pkg::FIFO_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bfdc_pkg::item_type          q_item,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic [bfdc_pkg::LEN_W-1:0]  program_length,
   bfdc_rsp_if.source                  rsp
);
   import bfdc_pkg::*;

   localparam int PA_W = $clog2(PROG_DEPTH);
   localparam int TP_W = $clog2(TAPE_DEPTH);
   localparam int FH_W = $clog2(FIFO_DEPTH);
   localparam int FC_W = $clog2(FIFO_DEPTH + 1);
   localparam int TS_W = FC_W + 1;
   localparam int DP_W = $clog2(PROG_DEPTH + 1) + 1;

   // memories
   logic [BYTE_W-1:0] prog_mem [PROG_DEPTH];
   logic [BYTE_W-1:0] tape_mem [TAPE_DEPTH];
   logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
   logic [BYTE_W-1:0] prog_rd_ff, tape_rd_ff, fifo_rd_ff;

   // memory controls
   logic              prog_we;
   logic [PA_W-1:0]   prog_waddr, prog_raddr;
   logic              tape_we;
   logic [TP_W-1:0]   tape_waddr;
   logic [BYTE_W-1:0] tape_wdata;
   logic              fifo_we;
   logic [FH_W-1:0]   fifo_waddr;

   // machine state
   back_state_type    state_ff, state_in;
   logic [IP_W-1:0]   ip_ff, ip_in;
   logic [TP_W-1:0]   tp_ff, tp_in;
   logic [FH_W-1:0]   head_ff, head_in;
   logic [FC_W-1:0]   count_ff, count_in;
   logic [DP_W-1:0]   depth_ff, depth_in;
   logic [TP_W-1:0]   clr_ff, clr_in;

   // response register
   logic              rv_ff, rv_in;
   logic              ro_valid_ff, ro_valid_in;
   logic [BYTE_W-1:0] ro_byte_ff, ro_byte_in;
   status_type        ro_status_ff, ro_status_in;
   logic [IP_W-1:0]   ro_index_ff, ro_index_in;

   // decode
   logic              slot_free, take, is_step, at_target, at_end;
   logic [EXT_W-1:0]  len_ext, ip_ext, ip_inc_ext, ip_dec_ext;
   logic              fwd_more, ip_zero, cell_zero;
   logic [BYTE_W-1:0] op, cell_byte;
   logic [DP_W-1:0]   fdepth, bdepth;
   logic [TS_W-1:0]   tail_sum;
   logic [FH_W-1:0]   tail, head_next;
   logic              finish;
   status_type        f_status;
   logic              f_ov;
   logic [BYTE_W-1:0] f_ob;

   assign len_ext    = (EXT_W'(program_length) > EXT_W'(PROG_DEPTH)) ?
                       EXT_W'(PROG_DEPTH) : EXT_W'(program_length);
   assign ip_ext     = EXT_W'(ip_ff);
   assign ip_inc_ext = ip_ext + 1'b1;
   assign ip_dec_ext = ip_ext - 1'b1;
   assign fwd_more   = (ip_inc_ext < len_ext);
   assign ip_zero    = (ip_ff == '0);

   assign slot_free  = !rv_ff || rsp.ready;
   assign take       = (state_ff == BK_IDLE) && q_valid && slot_free;
   assign q_pop      = take;
   assign is_step    = (q_item.kind == REQ_STEP);
   assign at_target  = (ip_ff == q_item.target_index);
   assign at_end     = (ip_ext >= len_ext);

   assign op         = prog_rd_ff;
   assign cell_byte  = tape_rd_ff;
   assign cell_zero  = (cell_byte == '0);

   // bracket nesting after the scanned character
   assign fdepth = depth_ff + DP_W'(op == OP_OPEN) - DP_W'(op == OP_CLOSE);
   assign bdepth = depth_ff + DP_W'(op == OP_CLOSE) - DP_W'(op == OP_OPEN);

   // fifo write slot and head advance
   assign tail_sum  = TS_W'(head_ff) + TS_W'(count_ff);
   assign tail      = (tail_sum >= TS_W'(FIFO_DEPTH)) ?
                      FH_W'(tail_sum - TS_W'(FIFO_DEPTH)) : FH_W'(tail_sum);
   assign head_next = (head_ff == FH_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == TP_W'(TAPE_DEPTH - 1)) state_in = BK_IDLE;
         end
         BK_IDLE: begin
            if (take && is_step && !at_target && !at_end) state_in = BK_EXEC;
         end
         BK_EXEC: begin
            if (op == OP_OPEN && cell_zero && fwd_more) begin
               state_in = BK_SCAN_F;
            end else if (op == OP_CLOSE && !cell_zero && !ip_zero) begin
               state_in = BK_SCAN_B;
            end else begin
               state_in = BK_IDLE;
            end
         end
         BK_SCAN_F: begin
            if (fdepth == '0 || !fwd_more) state_in = BK_IDLE;
         end
         BK_SCAN_B: begin
            if (bdepth == '0 || ip_zero) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      ip_in      = ip_ff;
      tp_in      = tp_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      depth_in   = depth_ff;
      clr_in     = clr_ff;
      prog_we    = 1'b0;
      prog_waddr = PA_W'(q_item.prog_addr);
      prog_raddr = ip_ext[PA_W-1:0];
      tape_we    = 1'b0;
      tape_waddr = tp_ff;
      tape_wdata = '0;
      fifo_we    = 1'b0;
      fifo_waddr = tail;
      finish     = 1'b0;
      f_status   = ST_ACCEPT;
      f_ov       = 1'b0;
      f_ob       = '0;
      unique case (state_ff)
         BK_CLEAR: begin
            tape_we    = 1'b1;
            tape_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (take) begin
               unique case (q_item.kind)
                  REQ_LOAD: begin
                     finish  = 1'b1;
                     prog_we = (EXT_W'(q_item.prog_addr) < EXT_W'(PROG_DEPTH));
                  end
                  REQ_PUSH: begin
                     finish = 1'b1;
                     if (count_ff < FC_W'(FIFO_DEPTH)) begin
                        fifo_we  = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_STEP: begin
                     if (at_target) begin
                        finish   = 1'b1;
                        f_status = ST_TARGET;
                     end else if (at_end) begin
                        finish   = 1'b1;
                        f_status = ST_END;
                     end
                  end
                  default: finish = 1'b1;
               endcase
            end
         end
         BK_EXEC: begin
            finish   = 1'b1;
            f_status = ST_EXEC;
            ip_in    = IP_W'(ip_inc_ext);
            case (op)
               OP_INC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_byte + 1'b1;
               end
               OP_DEC: begin
                  tape_we    = 1'b1;
                  tape_wdata = cell_byte - 1'b1;
               end
               OP_RIGHT: begin
                  if (tp_ff == TP_W'(TAPE_DEPTH - 1)) begin
                     tp_in    = '0;
                     f_status = ST_WRAP;
                  end else begin
                     tp_in = tp_ff + 1'b1;
                  end
               end
               OP_LEFT: begin
                  if (tp_ff == '0) begin
                     tp_in    = TP_W'(TAPE_DEPTH - 1);
                     f_status = ST_WRAP;
                  end else begin
                     tp_in = tp_ff - 1'b1;
                  end
               end
               OP_OUT: begin
                  f_ov = 1'b1;
                  f_ob = cell_byte;
               end
               OP_IN: begin
                  tape_we = 1'b1;
                  if (count_ff == '0) begin
                     tape_wdata = NEWLINE;
                  end else begin
                     tape_wdata = fifo_rd_ff;
                     head_in    = head_next;
                     count_in   = count_ff - 1'b1;
                  end
               end
               OP_OPEN: begin
                  // skip forward to the matching close bracket
                  if (cell_zero) begin
                     if (fwd_more) begin
                        finish     = 1'b0;
                        prog_raddr = ip_inc_ext[PA_W-1:0];
                        depth_in   = DP_W'(1);
                     end else begin
                        ip_in    = IP_W'(len_ext);
                        f_status = ST_NO_CLOSE;
                     end
                  end
               end
               OP_CLOSE: begin
                  // walk back to the matching open bracket
                  if (!cell_zero) begin
                     if (ip_zero) begin
                        ip_in    = '0;
                        f_status = ST_NO_OPEN;
                     end else begin
                        finish     = 1'b0;
                        ip_in      = IP_W'(ip_dec_ext);
                        prog_raddr = ip_dec_ext[PA_W-1:0];
                        depth_in   = DP_W'(1);
                     end
                  end
               end
               default: ;
            endcase
         end
         BK_SCAN_F: begin
            if (fdepth == '0) begin
               finish   = 1'b1;
               f_status = ST_EXEC;
               ip_in    = IP_W'(ip_inc_ext);
               depth_in = '0;
            end else if (fwd_more) begin
               ip_in      = IP_W'(ip_inc_ext);
               prog_raddr = ip_inc_ext[PA_W-1:0];
               depth_in   = fdepth;
            end else begin
               finish   = 1'b1;
               f_status = ST_NO_CLOSE;
               ip_in    = IP_W'(len_ext);
               depth_in = '0;
            end
         end
         BK_SCAN_B: begin
            if (bdepth == '0) begin
               finish   = 1'b1;
               f_status = ST_EXEC;
               depth_in = '0;
            end else if (ip_zero) begin
               finish   = 1'b1;
               f_status = ST_NO_OPEN;
               depth_in = '0;
            end else begin
               ip_in      = IP_W'(ip_dec_ext);
               prog_raddr = ip_dec_ext[PA_W-1:0];
               depth_in   = bdepth;
            end
         end
         default: ;
      endcase
   end

   // response register loads when an item finishes
   always_comb begin
      rv_in        = rv_ff && !rsp.ready;
      ro_valid_in  = ro_valid_ff;
      ro_byte_in   = ro_byte_ff;
      ro_status_in = ro_status_ff;
      ro_index_in  = ro_index_ff;
      if (finish) begin
         rv_in        = 1'b1;
         ro_valid_in  = f_ov;
         ro_byte_in   = f_ob;
         ro_status_in = f_status;
         ro_index_in  = ip_in;
      end
   end

   assign rsp.valid       = rv_ff;
   assign rsp.out_valid   = ro_valid_ff;
   assign rsp.out_byte    = ro_byte_ff;
   assign rsp.status      = ro_status_ff;
   assign rsp.instr_index = ro_index_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         ip_ff    <= '0;
         tp_ff    <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         depth_ff <= '0;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ip_ff    <= ip_in;
         tp_ff    <= tp_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         depth_ff <= depth_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      ro_valid_ff  <= ro_valid_in;
      ro_byte_ff   <= ro_byte_in;
      ro_status_ff <= ro_status_in;
      ro_index_ff  <= ro_index_in;
   end

   // program memory
   always_ff @(posedge clock) begin
      if (prog_we) prog_mem[prog_waddr] <= q_item.data_byte;
      prog_rd_ff <= prog_mem[prog_raddr];
   end

   // tape memory
   always_ff @(posedge clock) begin
      if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
      tape_rd_ff <= tape_mem[tp_ff];
   end

   // input byte memory
   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[fifo_waddr] <= q_item.data_byte;
      fifo_rd_ff <= fifo_mem[head_ff];
   end

endmodule

>>> rtl/brainfuck_debug_core.sv
// top level of the brainfuck debug core: front queue, back end, length register
// depends on bfdc_pkg, bfdc_req_if, bfdc_rsp_if, bfdc_front, bfdc_back, brainfuck_debug_core_assert.svh
//
//   channel   direction  words
//   req_chan  in         load byte, push input byte, step
//   rsp_chan  out        one response word per request word
//   csr       in         program_length write
//
// load, push and steps already at the target or the end answer in the cycle after leaving the queue;
// a plain instruction is a program read, then an execute step
// a bracket jump then scans the program port one byte at a time until the matching bracket
// after reset the tape is cleared, one cell a cycle;
// requests queue up but are not carried out until the clear is done
// a response word left waiting holds the back end idle; the two-entry queue takes words until it is full
`include "brainfuck_debug_core_assert.svh"

module brainfuck_debug_core #(
   parameter int PROG_DEPTH = bfdc_pkg::PROG_DEPTH_DEF,
   parameter int TAPE_DEPTH = bfdc_pkg::TAPE_DEPTH_DEF,
   parameter int FIFO_DEPTH = bfdc_pkg::FIFO_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   bfdc_req_if.sink                    req_chan,
   bfdc_rsp_if.source                  rsp_chan,
   input  logic                        csr_we,
   input  logic [bfdc_pkg::LEN_W-1:0]  csr_wdata
);
   import bfdc_pkg::*;

   item_type           q_item;
   logic               q_valid;
   logic               q_pop;
   logic [LEN_W-1:0]   program_length_ff, program_length_in;

   // program length register
   assign program_length_in = csr_we ? csr_wdata : program_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         program_length_ff <= '0;
      end else begin
         program_length_ff <= program_length_in;
      end
   end

   bfdc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_pop   (q_pop)
   );

   bfdc_back #(
      .PROG_DEPTH (PROG_DEPTH),
      .TAPE_DEPTH (TAPE_DEPTH),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_item         (q_item),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .program_length (program_length_ff),
      .rsp            (rsp_chan)
   );

   // checks
   `BFDC_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_chan.valid)
   `BFDC_ASSERT(a_emit_is_exec, clock, reset, (rsp_chan.valid && rsp_chan.out_valid) |-> (rsp_chan.status == ST_EXEC))
   `BFDC_ASSERT(a_quiet_byte_zero, clock, reset, (rsp_chan.valid && !rsp_chan.out_valid) |-> (rsp_chan.out_byte == '0))
   `BFDC_ASSERT(a_pop_has_item, clock, reset, q_pop |-> q_valid)

endmodule
